// File: sv/fdm_pkg.sv
// ---------------------------------------------------------------------------
// fdm_pkg
// Shared types, constants and helper functions of the frame difference
// motion detector.
// ---------------------------------------------------------------------------
package fdm_pkg;

	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 512;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned WIDTH_W    = 11;
	localparam int unsigned HEIGHT_W   = 10;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned SUM_W      = 28;
	localparam int unsigned FSUM_W     = 27;

	localparam int unsigned RESET_WIDTH  = 640;
	localparam int unsigned RESET_HEIGHT = 480;

	localparam int unsigned CSUM_W      = 10;
	localparam int unsigned RECIP_3     = 683;
	localparam int unsigned RECIP_SHIFT = 11;
	localparam int unsigned RPROD_W     = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned max);
		int unsigned r;
		if (v == 0) begin
			r = 1;
		end else if (v > max) begin
			r = max;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// The mean of three channels is formed by a multiply with 683/2048, which
	// gives the exact floor for every sum up to 765.
	function automatic logic [PIX_W-1:0] grey_of(
		input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b
	);
		logic [CSUM_W-1:0]  csum;
		logic [RPROD_W-1:0] prod;
		csum = CSUM_W'(r) + CSUM_W'(g) + CSUM_W'(b);
		prod = RPROD_W'(csum) * RPROD_W'(RECIP_3);
		return prod[RECIP_SHIFT +: PIX_W];
	endfunction

endpackage

// File: sv/fdm_pixel_if.sv
// ---------------------------------------------------------------------------
// fdm_pixel_if
// Valid/ready channel carrying one RGB pixel per transaction.
// ---------------------------------------------------------------------------
interface fdm_pixel_if;
	logic                     valid;
	logic                     ready;
	logic [fdm_pkg::PIX_W-1:0] red;
	logic [fdm_pkg::PIX_W-1:0] green;
	logic [fdm_pkg::PIX_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
	modport monitor (input valid, ready, red, green, blue);
endinterface

// File: sv/fdm_result_if.sv
// ---------------------------------------------------------------------------
// fdm_result_if
// Valid/ready channel carrying one per-pixel result per transaction.
// ---------------------------------------------------------------------------
interface fdm_result_if;
	logic                      valid;
	logic                      ready;
	logic [fdm_pkg::PIX_W-1:0]  difference;
	logic [fdm_pkg::FSUM_W-1:0] frame_sum;
	logic                      end_of_frame;

	modport source (output valid, difference, frame_sum, end_of_frame, input ready);
	modport sink (input valid, difference, frame_sum, end_of_frame, output ready);
	modport monitor (input valid, ready, difference, frame_sum, end_of_frame);
endinterface

// File: sv/fdm_cfg_if.sv
// ---------------------------------------------------------------------------
// fdm_cfg_if
// Register write channel: one register index and its data per transaction.
// ---------------------------------------------------------------------------
interface fdm_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [fdm_pkg::CFG_IDX_W-1:0]  index;
	logic [fdm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport monitor (input valid, ready, index, data);
endinterface

// File: sv/fdm_ram.sv
// ---------------------------------------------------------------------------
// fdm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read and a read enable.
// ---------------------------------------------------------------------------
module fdm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: sv/frame_difference_motion.sv
// ---------------------------------------------------------------------------
// frame_difference_motion
// Grey-level frame differencing against a stored reference frame, with a
// per-frame sum of the differences.
// ---------------------------------------------------------------------------
// The block accepts one pixel per clock cycle unless the result side stalls,
// and delivers results in order through its stage 1 and 2 registers. The
// rate is set by the reference frame store, a RAM of MAX_WIDTH * MAX_HEIGHT
// bytes that takes one read and one write per pixel. Locations not yet
// written since reset read as zero through a fill count, so the store needs
// no clearing pass and the block is ready right after reset. A read that
// hits the location written in the same cycle is served by forwarding.
// Frame size registers may be written only while no transaction is in flight.
module frame_difference_motion #(
	parameter int unsigned MAX_WIDTH  = fdm_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = fdm_pkg::DEF_MAX_HEIGHT
) (
	input  logic   clk,
	input  logic   arst_n,
	fdm_pixel_if.sink    pix,
	fdm_result_if.source res,
	fdm_cfg_if.sink      cfg
);
	import fdm_pkg::*;

	localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned FILL_W      = $clog2(STORE_DEPTH + 1);
	localparam int unsigned DW_W        = $clog2(MAX_WIDTH + 1);
	localparam int unsigned DH_W        = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned AREA_W      = DW_W + DH_W;
	localparam int unsigned RST_W       = clamp_dim(RESET_WIDTH, MAX_WIDTH);
	localparam int unsigned RST_H       = clamp_dim(RESET_HEIGHT, MAX_HEIGHT);
	localparam int unsigned RST_LAST    = RST_W * RST_H - 1;

	logic [DW_W-1:0]   width_q;
	logic [DH_W-1:0]   height_q;
	logic [ADDR_W-1:0] last_q;
	logic [DW_W-1:0]   width_new;
	logic [DH_W-1:0]   height_new;
	logic [AREA_W-1:0] area_w;
	logic [AREA_W-1:0] area_h;

	logic [ADDR_W-1:0] pos_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;

	logic              accept;
	logic              eof_in;
	logic              adv_s1;

	logic              valid_s1;
	logic [PIX_W-1:0]  grey_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              eof_s1;
	logic              known_s1;
	logic              fwd_s1;
	logic [PIX_W-1:0]  fwd_grey_s1;

	logic [PIX_W-1:0]  rdata;
	logic [PIX_W-1:0]  prev;
	logic [PIX_W-1:0]  diff;
	logic [SUM_W-1:0]  sum_next;

	logic              valid_s2;
	logic [PIX_W-1:0]  diff_s2;
	logic [FSUM_W-1:0] fsum_s2;
	logic              eof_s2;

	// Config: store clamped width, clamped data[9:0] as height, last pixel index.
	assign cfg.ready = 1'b1;

	always_comb begin
		if (cfg.data == '0) begin
			width_new = DW_W'(1);
		end else if (CFG_DATA_W'(cfg.data) > MAX_WIDTH) begin
			width_new = DW_W'(MAX_WIDTH);
		end else begin
			width_new = DW_W'(cfg.data);
		end
		if (cfg.data[HEIGHT_W-1:0] == '0) begin
			height_new = DH_W'(1);
		end else if (cfg.data[HEIGHT_W-1:0] > MAX_HEIGHT) begin
			height_new = DH_W'(MAX_HEIGHT);
		end else begin
			height_new = DH_W'(cfg.data[HEIGHT_W-1:0]);
		end
		area_w = AREA_W'(width_new) * AREA_W'(height_q);
		area_h = AREA_W'(width_q) * AREA_W'(height_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DW_W'(RST_W);
			height_q <= DH_W'(RST_H);
			last_q   <= ADDR_W'(RST_LAST);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FRAME_WIDTH: begin
					width_q <= width_new;
					last_q  <= ADDR_W'(area_w - AREA_W'(1));
				end
				REG_FRAME_HEIGHT: begin
					height_q <= height_new;
					last_q   <= ADDR_W'(area_h - AREA_W'(1));
				end
			endcase
		end
	end

	// Input side: position, end-of-frame decision and store read.
	assign adv_s1    = !valid_s2 || res.ready;
	assign pix.ready = !valid_s1 || adv_s1;
	assign accept    = pix.valid && pix.ready;
	assign eof_in    = pos_q >= last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			pos_q    <= eof_in ? '0 : pos_q + ADDR_W'(1);
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grey_s1     <= grey_of(pix.red, pix.green, pix.blue);
			addr_s1     <= pos_q;
			eof_s1      <= eof_in;
			known_s1    <= FILL_W'(pos_q) < fill_q;
			fwd_s1      <= valid_s1 && adv_s1 && (addr_s1 == pos_q);
			fwd_grey_s1 <= grey_s1;
		end
	end

	fdm_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (valid_s1 && adv_s1),
		.waddr (addr_s1),
		.wdata (grey_s1),
		.re    (accept),
		.raddr (pos_q),
		.rdata (rdata)
	);

	// Stage 1: difference, write-back and frame sum.
	always_comb begin
		if (fwd_s1) begin
			prev = fwd_grey_s1;
		end else if (known_s1) begin
			prev = rdata;
		end else begin
			prev = '0;
		end
		diff     = (grey_s1 >= prev) ? grey_s1 - prev : prev - grey_s1;
		sum_next = sum_q + SUM_W'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			sum_q    <= '0;
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				sum_q <= eof_s1 ? '0 : sum_next;
				if (FILL_W'(addr_s1) == fill_q) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			diff_s2 <= diff;
			fsum_s2 <= eof_s1 ? sum_next[FSUM_W-1:0] : '0;
			eof_s2  <= eof_s1;
		end
	end

	assign res.valid        = valid_s2;
	assign res.difference   = diff_s2;
	assign res.frame_sum    = fsum_s2;
	assign res.end_of_frame = eof_s2;
endmodule

// File: sv/fdm_checker.sv
// ---------------------------------------------------------------------------
// fdm_checker
// Port-level checks of the frame difference motion detector, bound to the
// top level.
// ---------------------------------------------------------------------------
module fdm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [fdm_pkg::PIX_W-1:0]  difference,
	input logic [fdm_pkg::FSUM_W-1:0] frame_sum,
	input logic                       end_of_frame
);
	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Count of accepted pixels whose result transaction has not completed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped before its transaction completed");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(difference) && $stable(frame_sum)
			&& $stable(end_of_frame))
		else $error("result payload changed while stalled");

	a_sum_only_at_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_frame |-> frame_sum == '0)
		else $error("frame sum nonzero on a result that does not end the frame");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result presented with no pixel in flight");

	a_in_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two pixels in flight");
endmodule

bind frame_difference_motion fdm_checker u_fdm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pix.valid),
	.in_ready     (pix.ready),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.difference   (res.difference),
	.frame_sum    (res.frame_sum),
	.end_of_frame (res.end_of_frame)
);
